/* design/cpa_pkg.sv */
package cpa_pkg;

  // Palette and slot table sizes
  localparam int NumColors = 16;
  localparam int MaxSlots  = 256;

  // Fixed field widths
  localparam int ColorW     = 9;
  localparam int DefW       = 4;
  localparam int SlotLimitW = 9;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 9;

  // Derived sizes
  localparam int MapSide  = NumColors + 2;
  localparam int MapDepth = MapSide * MapSide;
  localparam int MapAw    = $clog2(MapDepth);
  localparam int SlotAw   = $clog2(MaxSlots);
  localparam int LimW     = SlotAw + 1;
  localparam int MapEntW  = SlotAw + 1;
  localparam int PinBit   = SlotAw;
  localparam int CodeW    = $clog2(NumColors + 2);
  localparam int ClearLen = (MapDepth > MaxSlots) ? MapDepth : MaxSlots;
  localparam int ClrW     = $clog2(ClearLen);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegDefFg     = 2'd0,
    RegDefBg     = 2'd1,
    RegTermOk    = 2'd2,
    RegSlotLimit = 2'd3
  } cfg_reg_e;

  // Color settings seen by the request normalizer
  typedef struct packed {
    logic [DefW-1:0] def_fg;
    logic [DefW-1:0] def_bg;
    logic            term_ok;
  } cfg_t;

endpackage

/* design/cpa_ram.sv */
module cpa_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cpa_norm.sv */
module cpa_norm (
  input  logic                              opcode_i,
  input  logic signed [cpa_pkg::ColorW-1:0] fore_color_i,
  input  logic signed [cpa_pkg::ColorW-1:0] back_color_i,
  input  cpa_pkg::cfg_t                     cfg_i,
  output logic [cpa_pkg::MapAw-1:0]         idx_o,
  output logic                              skip_o
);
  import cpa_pkg::*;

  function automatic logic [CodeW-1:0] clamp_def(input logic [DefW-1:0] d);
    if (int'(d) >= NumColors) begin
      return CodeW'(NumColors - 1);
    end
    return CodeW'(d);
  endfunction

  logic             fg_dflt, bg_dflt, fg_rng, bg_rng;
  logic [CodeW-1:0] fg_code, bg_code;

  always_comb begin
    fg_dflt = (fore_color_i == '1);
    bg_dflt = (back_color_i == '1);
    fg_rng  = !fore_color_i[ColorW-1] &&
              ({1'b0, fore_color_i} < (ColorW + 1)'(NumColors));
    bg_rng  = !back_color_i[ColorW-1] &&
              ({1'b0, back_color_i} < (ColorW + 1)'(NumColors));

    // terminal default kept only when allowed, otherwise substitute
    if (fg_dflt && cfg_i.term_ok) begin
      fg_code = CodeW'(NumColors);
    end else if (fg_rng) begin
      fg_code = CodeW'(fore_color_i);
    end else begin
      fg_code = clamp_def(cfg_i.def_fg);
    end

    if (bg_dflt && cfg_i.term_ok) begin
      bg_code = CodeW'(NumColors + 1);
    end else if (bg_rng) begin
      bg_code = CodeW'(back_color_i);
    end else begin
      bg_code = clamp_def(cfg_i.def_bg);
    end

    idx_o  = MapAw'(fg_code) * MapAw'(MapSide) + MapAw'(bg_code);
    skip_o = (opcode_i && !((fg_dflt || fg_rng) && (bg_dflt || bg_rng))) ||
             (fg_code == CodeW'(NumColors) && bg_code == CodeW'(NumColors + 1));
  end

endmodule

/* design/color_pair_allocator.sv */
// Color pair allocator.
// Input channel (in_valid_i/in_ready_o) takes one request: opcode_i (0 get,
// 1 reserve), fore_color_i and back_color_i (-1 is the terminal default).
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// slot_index_o and status_o (1 when no slot could be found or reserved).
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i).
// The user must write it only while idle; the block does not enforce it.
// Pair mapping and slot contents live in two RAMs with registered reads.
// A hit or a reserve goes through the lookup and check states to the finish
// state, which loads its result into the output register and returns to idle
// for the next request; a get that misses adds a victim walk (pointer step,
// slot RAM read, then map RAM read of the slot's old pair per slot visited),
// up to 256 slots, closed by the install or the pointer step that gives up.
// After reset a clearing pass zeroes both RAMs, one entry per cycle; no
// request is accepted during it.
// The result sits in an output register, so the next request is accepted
// while a result still waits on a stalled receiver; a new result waits in
// the finish state until the register frees up.
module color_pair_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpa_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cpa_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic signed [cpa_pkg::ColorW-1:0]   fore_color_i,
  input  logic signed [cpa_pkg::ColorW-1:0]   back_color_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cpa_pkg::SlotAw-1:0]          slot_index_o,
  output logic                                status_o
);
  import cpa_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StLookup, StCheck, StStep, StOwner, StPinChk, StInstall, StFinish
  } state_e;

  // configuration registers
  cfg_t                  cfg_q;
  logic [SlotLimitW-1:0] slot_limit_q;

  // control and working registers
  state_e              state_q, state_d;
  logic [ClrW-1:0]     clr_q, clr_d;
  logic [SlotAw-1:0]   rc_q, rc_d;
  logic [SlotAw-1:0]   vp_q, vp_d;
  logic [LimW-1:0]     step_q, step_d;
  logic                op_q, op_d;
  logic                skip_q, skip_d;
  logic [MapAw-1:0]    idx_q, idx_d;
  logic [MapAw-1:0]    old_q, old_d;
  logic [SlotAw-1:0]   res_slot_q, res_slot_d;
  logic                res_stat_q, res_stat_d;
  logic                out_valid_q, out_valid_d;
  logic [SlotAw-1:0]   out_slot_q, out_slot_d;
  logic                out_stat_q, out_stat_d;

  // normalizer
  logic [MapAw-1:0] norm_idx;
  logic             norm_skip;

  // RAM ports
  logic               map_we, sc_we;
  logic [MapAw-1:0]   map_waddr, map_raddr;
  logic [MapEntW-1:0] map_wdata, map_rdata;
  logic [SlotAw-1:0]  sc_waddr, sc_raddr;
  logic [MapAw-1:0]   sc_wdata, sc_rdata;

  logic [LimW-1:0] lim, rc1, p_raw, p;

  cpa_norm u_norm (
    .opcode_i    (opcode_i),
    .fore_color_i(fore_color_i),
    .back_color_i(back_color_i),
    .cfg_i       (cfg_q),
    .idx_o       (norm_idx),
    .skip_o      (norm_skip)
  );

  cpa_ram #(.Depth(MapDepth), .Width(MapEntW)) u_pair_map (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  cpa_ram #(.Depth(MaxSlots), .Width(MapAw)) u_slot_colors (
    .clk_i  (clk_i),
    .we_i   (sc_we),
    .waddr_i(sc_waddr),
    .wdata_i(sc_wdata),
    .raddr_i(sc_raddr),
    .rdata_o(sc_rdata)
  );

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign slot_index_o = out_slot_q;
  assign status_o     = out_stat_q;

  // Usable slot count, saturated at the table size
  assign lim   = (slot_limit_q > SlotLimitW'(MaxSlots)) ? LimW'(MaxSlots)
                                                          : LimW'(slot_limit_q);
  assign rc1   = {1'b0, rc_q} + LimW'(1);
  assign p_raw = {1'b0, vp_q} + LimW'(1);
  // wrap the victim pointer back to the first unreserved slot
  assign p     = (p_raw >= lim) ? rc1 : p_raw;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rc_d        = rc_q;
    vp_d        = vp_q;
    step_d      = step_q;
    op_d        = op_q;
    skip_d      = skip_q;
    idx_d       = idx_q;
    old_d       = old_q;
    res_slot_d  = res_slot_q;
    res_stat_d  = res_stat_q;
    out_slot_d  = out_slot_q;
    out_stat_d  = out_stat_q;
    out_valid_d = out_valid_q && !out_ready_i;

    map_we    = 1'b0;
    map_waddr = idx_q;
    map_wdata = '0;
    map_raddr = idx_q;
    sc_we     = 1'b0;
    sc_waddr  = vp_q;
    sc_wdata  = idx_q;
    sc_raddr  = p[SlotAw-1:0];

    case (state_q)
      StClear: begin
        // zero both tables, one entry per cycle
        map_we    = (clr_q < ClrW'(MapDepth));
        map_waddr = clr_q[MapAw-1:0];
        sc_we     = (clr_q < ClrW'(MaxSlots));
        sc_waddr  = clr_q[SlotAw-1:0];
        sc_wdata  = '0;
        clr_d     = clr_q + ClrW'(1);
        if (clr_q == ClrW'(ClearLen - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          skip_d  = norm_skip;
          idx_d   = norm_idx;
          state_d = StLookup;
        end
      end
      StLookup: begin
        // map read of the pair issued here
        state_d = StCheck;
      end
      StCheck: begin
        res_stat_d = 1'b0;
        res_slot_d = map_rdata[SlotAw-1:0];
        state_d    = StFinish;
        if (skip_q) begin
          res_slot_d = '0;
        end else if (!op_q) begin
          if (map_rdata == '0) begin
            step_d  = '0;
            state_d = StStep;
          end
        end else if (!map_rdata[PinBit]) begin
          if (rc1 < lim) begin
            // pin the pair to the next reserved slot
            rc_d       = rc1[SlotAw-1:0];
            map_we     = 1'b1;
            map_wdata  = {1'b1, rc1[SlotAw-1:0]};
            sc_we      = 1'b1;
            sc_waddr   = rc1[SlotAw-1:0];
            res_slot_d = rc1[SlotAw-1:0];
          end else begin
            res_stat_d = 1'b1;
          end
        end
      end
      StStep: begin
        if (step_q == LimW'(MaxSlots) || p >= lim) begin
          res_slot_d = '0;
          res_stat_d = 1'b1;
          state_d    = StFinish;
        end else begin
          // advance the pointer and fetch the slot's current pair
          vp_d    = p[SlotAw-1:0];
          step_d  = step_q + LimW'(1);
          state_d = StOwner;
        end
      end
      StOwner: begin
        old_d     = sc_rdata;
        map_raddr = sc_rdata;
        state_d   = StPinChk;
      end
      StPinChk: begin
        if (map_rdata[PinBit]) begin
          state_d = StStep;
        end else begin
          // drop the old owner's mapping
          map_we    = 1'b1;
          map_waddr = old_q;
          map_wdata = '0;
          state_d   = StInstall;
        end
      end
      StInstall: begin
        map_we     = 1'b1;
        map_waddr  = idx_q;
        map_wdata  = {1'b0, vp_q};
        sc_we      = 1'b1;
        sc_waddr   = vp_q;
        sc_wdata   = idx_q;
        res_slot_d = vp_q;
        res_stat_d = 1'b0;
        state_d    = StFinish;
      end
      StFinish: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_slot_d  = res_slot_q;
          out_stat_d  = res_stat_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      rc_q         <= '0;
      vp_q         <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      cfg_q.def_fg <= DefW'(7);
      cfg_q.def_bg <= '0;
      cfg_q.term_ok <= 1'b0;
      slot_limit_q <= SlotLimitW'(MaxSlots);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rc_q        <= rc_d;
      vp_q        <= vp_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegDefFg:     cfg_q.def_fg  <= cfg_data_i[DefW-1:0];
          RegDefBg:     cfg_q.def_bg  <= cfg_data_i[DefW-1:0];
          RegTermOk:    cfg_q.term_ok <= cfg_data_i[0];
          RegSlotLimit: slot_limit_q  <= cfg_data_i[SlotLimitW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    skip_q     <= skip_d;
    idx_q      <= idx_d;
    old_q      <= old_d;
    res_slot_q <= res_slot_d;
    res_stat_q <= res_stat_d;
    out_slot_q <= out_slot_d;
    out_stat_q <= out_stat_d;
  end

endmodule
